/* rtl/selsort_pkg.sv */
package selsort_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int DATA_W    = 32;
  localparam int IDX_W     = $clog2(MAX_ITEMS);
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     is_last;
  } in_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     end_of_set;
    logic                     overflowed;
  } out_req_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_RD_FRONT,
    ST_SCAN,
    ST_SWAP_A,
    ST_SWAP_B,
    ST_OUT_RD,
    ST_OUT_CAP
  } state_t;

endpackage

/* rtl/selsort_ram.sv */
module selsort_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/selection_sorter_core.sv */
// Loading accepts one request per cycle; in_ready stays high while loading.
// Sorting a set of n makes passes f = 0..n-2, each a front read, a tail
// scan via the single read port of the element RAM and two swap writes.
// Each result then has a RAM read and a capture, held by output stalls.
// Synchronous active-low reset clears the sequencer, count, overflow flag
// and output valid; the element RAM is not cleared.
module selection_sorter_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  selsort_pkg::in_req_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output selsort_pkg::out_req_t out_data
);
  import selsort_pkg::*;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]         count_r, count_nxt;
  logic                     ovf_r, ovf_nxt;
  logic [IDX_W-1:0]         front_r, front_nxt;
  logic [IDX_W-1:0]         rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0]         best_r, best_nxt;
  logic signed [DATA_W-1:0] best_val_r, best_val_nxt;
  logic signed [DATA_W-1:0] held_r, held_nxt;
  logic [IDX_W-1:0]         out_idx_r, out_idx_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_req_t                 out_data_r, out_data_nxt;

  logic                     ram_we;
  logic [IDX_W-1:0]         ram_waddr;
  logic [DATA_W-1:0]        ram_wdata;
  logic                     ram_re;
  logic [IDX_W-1:0]         ram_raddr;
  logic [DATA_W-1:0]        ram_rdata;
  logic signed [DATA_W-1:0] rd_val;

  logic                     has_room;
  logic [CNT_W-1:0]         n_after;
  logic                     in_acc;
  logic                     scan_done;
  logic                     more_passes;
  logic                     out_last;
  logic                     out_load;

  assign rd_val      = $signed(ram_rdata);
  assign has_room    = count_r < CNT_W'(MAX_ITEMS);
  assign n_after     = has_room ? count_r + CNT_W'(1) : count_r;
  assign in_acc      = in_valid && in_ready;
  assign scan_done   = {1'b0, rd_idx_r} == count_r - CNT_W'(1);
  assign more_passes = ({1'b0, front_r} + CNT_W'(2)) < count_r;
  assign out_last    = {1'b0, out_idx_r} == count_r - CNT_W'(1);
  assign out_load    = !out_valid_r || out_ready;

  selsort_ram #(
    .WIDTH(DATA_W),
    .DEPTH(MAX_ITEMS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: begin
        if (in_acc && in_data.is_last) begin
          state_nxt = (n_after >= CNT_W'(2)) ? ST_RD_FRONT : ST_OUT_RD;
        end
      end
      ST_RD_FRONT: state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (scan_done) begin
          state_nxt = ST_SWAP_A;
        end
      end
      ST_SWAP_A: state_nxt = ST_SWAP_B;
      ST_SWAP_B: state_nxt = more_passes ? ST_RD_FRONT : ST_OUT_RD;
      ST_OUT_RD: state_nxt = ST_OUT_CAP;
      ST_OUT_CAP: begin
        if (out_load) begin
          state_nxt = out_last ? ST_LOAD : ST_OUT_RD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  // outputs: handshake and RAM control
  always_comb begin
    in_ready  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = count_r[IDX_W-1:0];
    ram_wdata = in_data.value;
    ram_re    = 1'b0;
    ram_raddr = front_r;
    case (state_r)
      ST_LOAD: begin
        in_ready = 1'b1;
        ram_we   = in_valid && has_room;
      end
      ST_RD_FRONT: begin
        ram_re    = 1'b1;
        ram_raddr = front_r;
      end
      ST_SCAN: begin
        ram_re    = 1'b1;
        ram_raddr = rd_idx_r + IDX_W'(1);
      end
      ST_SWAP_A: begin
        ram_we    = 1'b1;
        ram_waddr = best_r;
        ram_wdata = held_r;
      end
      ST_SWAP_B: begin
        ram_we    = 1'b1;
        ram_waddr = front_r;
        ram_wdata = best_val_r;
      end
      ST_OUT_RD: begin
        ram_re    = 1'b1;
        ram_raddr = out_idx_r;
      end
      ST_OUT_CAP: begin
        ram_re = 1'b0;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // datapath
  always_comb begin
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    front_nxt     = front_r;
    rd_idx_nxt    = rd_idx_r;
    best_nxt      = best_r;
    best_val_nxt  = best_val_r;
    held_nxt      = held_r;
    out_idx_nxt   = out_idx_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          count_nxt = n_after;
          if (!has_room) begin
            ovf_nxt = 1'b1;
          end
          front_nxt   = '0;
          out_idx_nxt = '0;
        end
      end
      ST_RD_FRONT: begin
        rd_idx_nxt = front_r;
      end
      ST_SCAN: begin
        rd_idx_nxt = rd_idx_r + IDX_W'(1);
        if (rd_idx_r == front_r) begin
          held_nxt     = rd_val;
          best_nxt     = front_r;
          best_val_nxt = rd_val;
        end else if (rd_val < best_val_r) begin
          best_nxt     = rd_idx_r;
          best_val_nxt = rd_val;
        end
      end
      ST_SWAP_B: begin
        front_nxt = front_r + IDX_W'(1);
      end
      ST_OUT_CAP: begin
        if (out_load) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.sorted_value = rd_val;
          out_data_nxt.end_of_set = out_last;
          out_data_nxt.overflowed = ovf_r;
          out_idx_nxt             = out_idx_r + IDX_W'(1);
          if (out_last) begin
            count_nxt = '0;
            ovf_nxt   = 1'b0;
          end
        end
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    front_r    <= front_nxt;
    rd_idx_r   <= rd_idx_nxt;
    best_r     <= best_nxt;
    best_val_r <= best_val_nxt;
    held_r     <= held_nxt;
    out_idx_r  <= out_idx_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_ITEMS))
    else $error("element count above store size");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> count_r == CNT_W'(MAX_ITEMS))
    else $error("overflow flagged with store not full");

  a_scan_front: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (({1'b0, front_r} + CNT_W'(1)) < count_r))
    else $error("scan pass started with no tail to sort");

  a_scan_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && rd_idx_r != front_r) |-> rd_idx_r > front_r)
    else $error("scan index behind front of tail");

  a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD && in_acc && in_data.is_last) |=> !in_ready)
    else $error("input taken right after last element");
`endif

endmodule
